// ----- sv/ppu_pkg.sv -----
`timescale 1ns / 1ps

package ppu_pkg;

   // fixed field and register widths
   localparam int BYTE_BITS  = 8;
   localparam int PIXEL_BITS = 16;
   localparam int BPP_BITS   = 5;
   localparam int DIM_BITS   = 13;
   localparam int BUF_BITS   = 23;
   localparam int HELD_BITS  = 5;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 13;

   // pixel width limits
   localparam logic [BPP_BITS-1:0] BPP_MIN = 5'd8;
   localparam logic [BPP_BITS-1:0] BPP_MAX = 5'd16;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BITS_PER_PIXEL = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_PIXELS     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_ROWS     = 2'd2;

   // register reset values
   localparam logic [BPP_BITS-1:0] BPP_RESET  = 5'd16;
   localparam logic [DIM_BITS-1:0] DIM_RESET  = 13'd4096;

   // pixel produced by the bit unpacker for one byte
   typedef struct packed {
      logic                  done;
      logic [PIXEL_BITS-1:0] value;
   } pix_type;

endpackage

// ----- sv/ppu_bit_unpack.sv -----
`timescale 1ns / 1ps

module ppu_bit_unpack (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [ppu_pkg::BYTE_BITS-1:0] raw_byte,
   input  logic [ppu_pkg::BPP_BITS-1:0]  bpp_raw,
   input  logic                          row_last,
   output ppu_pkg::pix_type              pix
);
   import ppu_pkg::*;

   logic [BUF_BITS-1:0]   buf_ff, buf_in;
   logic [HELD_BITS-1:0]  held_ff, held_in;
   logic [BPP_BITS-1:0]   bpp;
   logic [BUF_BITS-1:0]   buf_sum;
   logic [HELD_BITS-1:0]  held_sum;
   logic [HELD_BITS-1:0]  rem;
   logic [BUF_BITS-1:0]   shifted;
   logic [PIXEL_BITS-1:0] value_mask;
   logic [BUF_BITS-1:0]   rem_mask;

   // clamp pixel width into the legal range
   always_comb begin
      priority if (bpp_raw < BPP_MIN) begin
         bpp = BPP_MIN;
      end else if (bpp_raw > BPP_MAX) begin
         bpp = BPP_MAX;
      end else begin
         bpp = bpp_raw;
      end
   end

   // append the new byte and take the oldest bpp bits
   always_comb begin
      buf_sum    = {buf_ff[BUF_BITS-BYTE_BITS-1:0], raw_byte};
      held_sum   = held_ff + HELD_BITS'(BYTE_BITS);
      rem        = held_sum - bpp;
      shifted    = buf_sum >> rem;
      value_mask = {PIXEL_BITS{1'b1}} >> (BPP_MAX - bpp);
      rem_mask   = {BUF_BITS{1'b1}} >> (HELD_BITS'(BUF_BITS) - rem);
      pix.done   = (held_sum >= bpp);
      pix.value  = shifted[PIXEL_BITS-1:0] & value_mask;
   end

   // next buffer contents, flushed to the byte boundary at row end
   always_comb begin
      buf_in  = buf_ff;
      held_in = held_ff;
      if (step) begin
         priority if (pix.done && row_last) begin
            buf_in  = '0;
            held_in = '0;
         end else if (pix.done) begin
            buf_in  = buf_sum & rem_mask;
            held_in = rem;
         end else begin
            buf_in  = buf_sum;
            held_in = held_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff  <= '0;
         held_ff <= '0;
      end else begin
         buf_ff  <= buf_in;
         held_ff <= held_in;
      end
   end

endmodule

// ----- sv/ppu_pos_counter.sv -----
`timescale 1ns / 1ps

module ppu_pos_counter #(
   parameter int MAX_COUNT = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [ppu_pkg::DIM_BITS-1:0] limit_raw,
   output logic                         last
);
   import ppu_pkg::*;

   localparam int IDX_BITS = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
   localparam int MAX_BITS = $clog2(MAX_COUNT + 1);
   localparam int CMP_BITS = (MAX_BITS > DIM_BITS) ? MAX_BITS : DIM_BITS;
   localparam logic [CMP_BITS-1:0] CMP_MAX = CMP_BITS'(MAX_COUNT);

   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic [CMP_BITS-1:0] limit_ext;
   logic [CMP_BITS-1:0] limit;
   logic [CMP_BITS-1:0] next_pos;

   // clamp the limit between one and the maximum
   always_comb begin
      limit_ext = CMP_BITS'(limit_raw);
      priority if (limit_ext == '0) begin
         limit = CMP_BITS'(1);
      end else if (limit_ext > CMP_MAX) begin
         limit = CMP_MAX;
      end else begin
         limit = limit_ext;
      end
   end

   // an index at or past the limit also counts as last
   always_comb begin
      next_pos = CMP_BITS'(idx_ff) + CMP_BITS'(1);
      last     = (next_pos >= limit);
      idx_in   = idx_ff;
      if (advance) begin
         idx_in = last ? '0 : next_pos[IDX_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ----- sv/packed_raw_pixel_unpacker.sv -----
`timescale 1ns / 1ps

// Unpacks a stream of raw image bytes into pixels of 8 to 16 bits each,
// most significant bit first. Every row starts on a byte boundary.
//
// req_*  : one byte per transfer.
// rsp_*  : one pixel per transfer, tlast on the last pixel of a row,
//          tuser set on the last pixel of the image; counting then wraps.
// csr_*  : register writes (index 0 bits per pixel, 1 row pixels,
//          2 image rows); always ready, take effect at once. Other
//          indexes are dropped. Write only while no transfer is in flight.
//
// One byte is accepted every cycle. A pixel appears on rsp in the cycle after
// the byte that completes it; bytes that complete none give no transfer.
// A single output register holds a pixel while the receiver stalls;
// req_tready drops only while that register is full and rsp_tready is low.
// Reset clears the bit buffer, the row and column positions and the
// output valid flag, and loads 16 bits per pixel and 4096 by 4096 pixels.
module packed_raw_pixel_unpacker #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   // raw_byte
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,
   // pixel_value
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,
   output logic                               rsp_tlast,
   // image_end
   output logic                               rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ppu_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ppu_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import ppu_pkg::*;

   logic [BPP_BITS-1:0]   bpp_ff;
   logic [DIM_BITS-1:0]   row_pixels_ff;
   logic [DIM_BITS-1:0]   image_rows_ff;
   logic                  rsp_valid_ff;
   logic [PIXEL_BITS-1:0] rsp_pixel_ff;
   logic                  rsp_last_ff;
   logic                  rsp_user_ff;
   logic                  accept;
   logic                  col_last;
   logic                  row_last;
   pix_type               pix;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff        <= BPP_RESET;
         row_pixels_ff <= DIM_RESET;
         image_rows_ff <= DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BITS_PER_PIXEL: bpp_ff        <= csr_data[BPP_BITS-1:0];
            CSR_ROW_PIXELS:     row_pixels_ff <= csr_data[DIM_BITS-1:0];
            CSR_IMAGE_ROWS:     image_rows_ff <= csr_data[DIM_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // a byte is taken whenever the output slot is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   ppu_bit_unpack u_unpack (
      .clock    (clock),
      .reset    (reset),
      .step     (accept),
      .raw_byte (req_tdata),
      .bpp_raw  (bpp_ff),
      .row_last (col_last),
      .pix      (pix)
   );

   ppu_pos_counter #(
      .MAX_COUNT (MAX_WIDTH)
   ) u_column (
      .clock     (clock),
      .reset     (reset),
      .advance   (accept && pix.done),
      .limit_raw (row_pixels_ff),
      .last      (col_last)
   );

   ppu_pos_counter #(
      .MAX_COUNT (MAX_HEIGHT)
   ) u_row (
      .clock     (clock),
      .reset     (reset),
      .advance   (accept && pix.done && col_last),
      .limit_raw (image_rows_ff),
      .last      (row_last)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= pix.done;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pix.done) begin
         rsp_pixel_ff <= pix.value;
         rsp_last_ff  <= col_last;
         rsp_user_ff  <= col_last && row_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- sim/pixel_stream_checker.sv -----
`timescale 1ns / 1ps

module pixel_stream_checker #(
   parameter int MAX_COLS  = 4096,
   parameter int MAX_LINES = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [ppu_pkg::BYTE_BITS-1:0]      req_tdata,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [ppu_pkg::PIXEL_BITS-1:0]     rsp_tdata,
   input  logic                               rsp_tlast,
   input  logic                               rsp_tuser,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [ppu_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ppu_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 bytes_seen,
   output int                                 pixels_seen,
   output int                                 rows_seen,
   output int                                 images_seen
);
   import ppu_pkg::*;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] value;
      logic                  row_end;
      logic                  image_end;
   } pixel_rec_type;

   // register copies
   logic [BPP_BITS-1:0] cfg_bpp;
   logic [DIM_BITS-1:0] cfg_cols;
   logic [DIM_BITS-1:0] cfg_lines;

   // unpacking state
   logic [BUF_BITS-1:0]  shift_reg;
   logic [HELD_BITS-1:0] bits_held;
   logic [11:0]          col_pos;
   logic [11:0]          line_pos;

   pixel_rec_type pixels_due[$];

   // shift one byte in and queue the pixel it completes, if any
   task automatic unpack_byte(input logic [BYTE_BITS-1:0] b);
      int unsigned   bpp;
      int unsigned   width;
      int unsigned   height;
      int unsigned   window;
      pixel_rec_type rec;
      bpp    = (cfg_bpp < BPP_MIN) ? BPP_MIN : (cfg_bpp > BPP_MAX) ? BPP_MAX : cfg_bpp;
      width  = (cfg_cols == 0) ? 1 : (cfg_cols > MAX_COLS) ? MAX_COLS : cfg_cols;
      height = (cfg_lines == 0) ? 1 : (cfg_lines > MAX_LINES) ? MAX_LINES : cfg_lines;
      shift_reg = {shift_reg[BUF_BITS-BYTE_BITS-1:0], b};
      bits_held = HELD_BITS'(bits_held + BYTE_BITS);
      if (bits_held >= bpp) begin
         window    = 32'(shift_reg) >> (bits_held - bpp);
         rec.value = PIXEL_BITS'(window & ((32'd1 << bpp) - 1));
         bits_held = HELD_BITS'(bits_held - bpp);
         shift_reg = shift_reg & BUF_BITS'((32'd1 << bits_held) - 1);
         rec.row_end   = 1'b0;
         rec.image_end = 1'b0;
         // row end drops the leftover bits so the next row is byte aligned
         if (col_pos + 1 >= width) begin
            rec.row_end = 1'b1;
            col_pos     = '0;
            shift_reg   = '0;
            bits_held   = '0;
            if (line_pos + 1 >= height) begin
               rec.image_end = 1'b1;
               line_pos      = '0;
            end else begin
               line_pos = line_pos + 1'b1;
            end
         end else begin
            col_pos = col_pos + 1'b1;
         end
         pixels_due = {pixels_due, rec};
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_bpp     = BPP_RESET;
         cfg_cols    = DIM_RESET;
         cfg_lines   = DIM_RESET;
         shift_reg   = '0;
         bits_held   = '0;
         col_pos     = '0;
         line_pos    = '0;
         pixels_due.delete();
         fail_count  = 0;
         bytes_seen  = 0;
         pixels_seen = 0;
         rows_seen   = 0;
         images_seen = 0;
      end else begin
         // register writes, unknown indexes dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BITS_PER_PIXEL: cfg_bpp   = csr_data[BPP_BITS-1:0];
               CSR_ROW_PIXELS:     cfg_cols  = csr_data;
               CSR_IMAGE_ROWS:     cfg_lines = csr_data;
               default: ;
            endcase
         end
         // compare each pixel transfer with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            pixels_seen++;
            if (pixels_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected pixel, expected none, got %h last %b user %b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               pixel_rec_type want;
               want = pixels_due.pop_front();
               if (want.row_end) rows_seen++;
               if (want.image_end) images_seen++;
               if (rsp_tdata !== want.value || rsp_tlast !== want.row_end ||
                   rsp_tuser !== want.image_end) begin
                  fail_count++;
                  $display("%0t: pixel mismatch, expected %h last %b user %b, got %h %b %b",
                           $time, want.value, want.row_end, want.image_end,
                           rsp_tdata, rsp_tlast, rsp_tuser);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            bytes_seen++;
            unpack_byte(req_tdata);
         end
      end
      pending = pixels_due.size();
   end

endmodule

// ----- sim/tb_packed_raw_pixel_unpacker.sv -----
`timescale 1ns / 1ps

module tb_packed_raw_pixel_unpacker;
   import ppu_pkg::*;

   localparam int MAX_COLS     = 4096;
   localparam int MAX_LINES    = 4096;
   localparam int RANDOM_BYTES = 1520;
   localparam int LONG_HOLD    = 150;
   localparam int IDLE_LIMIT   = 2000;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [7:0]                req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [15:0]               rsp_tdata;
   logic                      rsp_tlast;
   logic                      rsp_tuser;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   int fail_count;
   int pending;
   int bytes_seen;
   int pixels_seen;
   int rows_seen;
   int images_seen;

   int hold_request = 0;
   bit burst_tx     = 1'b0;
   int idle_cycles;

   packed_raw_pixel_unpacker #(
      .MAX_WIDTH  (MAX_COLS),
      .MAX_HEIGHT (MAX_LINES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   pixel_stream_checker #(
      .MAX_COLS  (MAX_COLS),
      .MAX_LINES (MAX_LINES)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .bytes_seen  (bytes_seen),
      .pixels_seen (pixels_seen),
      .rows_seen   (rows_seen),
      .images_seen (images_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("tb_packed_raw_pixel_unpacker failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // pixel receiver: random stalls, quiet stretches, long holds on request
   initial begin
      int stall;
      int rx_count;
      int holds_done;
      bit quiet_rx;
      rx_count   = 0;
      holds_done = 0;
      quiet_rx   = 1'b0;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (holds_done < hold_request) begin
            holds_done++;
            stall = LONG_HOLD;
         end else if (quiet_rx) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 12);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rx_count++;
         if (rx_count % 40 == 0) quiet_rx = ($urandom_range(0, 2) == 0);
      end
   end

   // one byte transfer, then the sender's own gap
   task automatic send_byte(input logic [7:0] b, input bit last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      gap = burst_tx ? 0 : $urandom_range(0, 12);
      if (gap > 0 || last) req_tvalid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   // random strip bytes, with all-zero and all-one bytes mixed in
   task automatic send_run(input int n);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 15))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
         endcase
         send_byte(b, i == n - 1);
      end
   endtask

   // wait for every predicted pixel, then allow for a byte still in flight
   task automatic settle();
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input int bpp,
                            input int cols,
                            input int lines,
                            input bit spare);
      settle();
      write_reg(CSR_BITS_PER_PIXEL, CSR_DATA_BITS'(bpp));
      write_reg(CSR_ROW_PIXELS, CSR_DATA_BITS'(cols));
      write_reg(CSR_IMAGE_ROWS, CSR_DATA_BITS'(lines));
      if (spare) write_reg(CSR_SPARE, CSR_DATA_BITS'($urandom_range(0, 8191)));
      csr_valid <= 1'b0;
   endtask

   initial begin
      int sent;
      int settings;
      int n;
      int bpp;
      int cols;
      int lines;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_BITS_PER_PIXEL;
      csr_data   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: 16 bit pixels
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      // half a pixel held, then the pixel width shrinks
      send_byte(8'hC3, 1'b1);
      configure(8, 4096, 4096, 1'b0);
      send_byte(8'h3C, 1'b0);
      send_byte(8'h7E, 1'b1);
      // zero sizes act as one, column already past the new row end
      configure(0, 0, 0, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      // oversized values clamp to the maximum
      configure(31, 8191, 8191, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b1);
      // 12 bit pixels, short rows with discarded tail bits, unused index
      configure(12, 3, 2, 1'b1);
      send_run(10);
      settings = 5;
      sent     = 0;

      // random settings, each followed by a run of bytes
      while (sent < RANDOM_BYTES) begin
         settings++;
         bpp   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31)
                                             : $urandom_range(8, 16);
         cols  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191)
                                             : $urandom_range(1, 12);
         lines = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191)
                                             : $urandom_range(1, 6);
         configure(bpp, cols, lines, $urandom_range(0, 5) == 0);
         burst_tx = ($urandom_range(0, 3) == 0);
         n = $urandom_range(1, 60);
         // back-pressure: receiver holds off while bytes keep coming
         if (settings == 12 || settings == 30) begin
            hold_request++;
            burst_tx = 1'b1;
            n = 80;
         end
         send_run(n);
         sent += n;
      end

      settle();
      repeat (4) @(posedge clock);
      $display("%0d bytes over %0d register settings gave %0d pixels", bytes_seen, settings,
               pixels_seen);
      $display("%0d row ends and %0d image ends checked", rows_seen, images_seen);
      if (fail_count == 0) begin
         $display("tb_packed_raw_pixel_unpacker passed");
      end else begin
         $display("tb_packed_raw_pixel_unpacker failed");
      end
      $finish;
   end

endmodule
